@@ hw/rtl/ukvt_pkg.sv @@
// Shared codes and token control type for the key/value table.
package ukvt_pkg;

	localparam logic [1:0] ACT_PUT   = 2'd0;
	localparam logic [1:0] ACT_TAKE  = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOKEY = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	// Control part of the search token that walks down the cell row.
	typedef struct packed {
		logic valid;
		logic take;
		logic hit;
	} tok_ctrl_t;

endpackage

@@ hw/rtl/ukvt_cell.sv @@
// One table slot: holds an entry and passes the search token to the next slot.
module ukvt_cell import ukvt_pkg::*; #(
	parameter int IDX        = 0,
	parameter int CW         = 7,
	parameter int KEY_BITS   = 16,
	parameter int VALUE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [CW-1:0]         count,
	input  tok_ctrl_t             tok_in,
	input  logic [KEY_BITS-1:0]   tok_key_in,
	input  logic [VALUE_BITS-1:0] tok_val_in,
	output tok_ctrl_t             tok_out,
	output logic [KEY_BITS-1:0]   tok_key_out,
	output logic [VALUE_BITS-1:0] tok_val_out,
	input  logic                  pull_in,
	input  logic [KEY_BITS-1:0]   nbr_key,
	input  logic [VALUE_BITS-1:0] nbr_val,
	output logic                  pull_out,
	output logic [KEY_BITS-1:0]   key_out,
	output logic [VALUE_BITS-1:0] val_out
);

	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	tok_ctrl_t             tok_q;
	logic [KEY_BITS-1:0]   tok_key_q;
	logic [VALUE_BITS-1:0] tok_val_q;
	logic                  live;
	logic                  is_tail;
	logic                  match;

	always_comb begin
		live     = CW'(IDX) < count;
		is_tail  = CW'(IDX) == count;
		match    = live && (key_q == tok_key_in);
		// after a removal every later live slot moves up one place
		pull_out = tok_in.valid && tok_in.take && tok_in.hit && live;
	end

	always_ff @(posedge clk) begin
		if (tok_in.valid) begin
			if (!tok_in.take) begin
				if (match) begin
					val_q <= tok_val_in;
				end else if (is_tail && !tok_in.hit) begin
					key_q <= tok_key_in;
					val_q <= tok_val_in;
				end
			end
		end else if (pull_in) begin
			key_q <= nbr_key;
			val_q <= nbr_val;
		end
	end

	always_ff @(posedge clk) begin
		tok_key_q <= tok_key_in;
		tok_val_q <= (tok_in.take && match && !tok_in.hit) ? val_q : tok_val_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid <= tok_in.valid;
			tok_q.take  <= tok_in.take;
			tok_q.hit   <= tok_in.valid && (tok_in.hit || match);
		end
	end

	assign tok_out     = tok_q;
	assign tok_key_out = tok_key_q;
	assign tok_val_out = tok_val_q;
	assign key_out     = key_q;
	assign val_out     = val_q;

endmodule

@@ hw/rtl/unordered_key_value_table.sv @@
// Top level of the unordered key/value table: cell row and request control.
//
// One request channel: action, key and value are taken at a rising edge with
// start high and busy low. Every request gives exactly one result on status,
// out_key, out_value and entry_count, marked by done for one cycle; the
// receiver cannot hold it off.
// Put and take send a search token down a row of TABLE_DEPTH cells, one cell
// per cycle; busy is high from the request until done rises, so a new put or
// take is not taken before the last one is answered. Clear, put on a full
// table, take on an empty table and the unused action code are answered the
// cycle after the request with busy staying low, one per cycle.
// A take compacts the row: entries behind the removed one move up a slot as
// the token passes them.
// Reset empties the table (entry count zero) and drops any request in flight;
// entry contents are not cleared and are never read before being written.
module unordered_key_value_table import ukvt_pkg::*; #(
	parameter int TABLE_DEPTH = 64,
	parameter int KEY_BITS    = 16,
	parameter int VALUE_BITS  = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [1:0]                            action,
	input  logic [KEY_BITS-1:0]                   key,
	input  logic [VALUE_BITS-1:0]                 value,
	output logic                                  done,
	output logic [1:0]                            status,
	output logic [KEY_BITS-1:0]                   out_key,
	output logic [VALUE_BITS-1:0]                 out_value,
	output logic [$clog2(TABLE_DEPTH + 1)-1:0]    entry_count
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic {IDLE, SCAN} state_t;

	state_t                state_q;
	logic [CW-1:0]         count_q;
	logic                  accept;
	logic                  launch;
	tok_ctrl_t             tok_head;
	tok_ctrl_t             tok     [TABLE_DEPTH];
	logic [KEY_BITS-1:0]   tok_key [TABLE_DEPTH];
	logic [VALUE_BITS-1:0] tok_val [TABLE_DEPTH];
	logic                  pull    [TABLE_DEPTH];
	logic [KEY_BITS-1:0]   cell_key[TABLE_DEPTH];
	logic [VALUE_BITS-1:0] cell_val[TABLE_DEPTH];
	tok_ctrl_t             tail;

	assign busy   = (state_q == SCAN);
	assign accept = start && !busy;
	assign launch = accept && (((action == ACT_PUT) && (count_q != CW'(TABLE_DEPTH)))
		|| ((action == ACT_TAKE) && (count_q != '0)));
	assign tail   = tok[TABLE_DEPTH-1];

	always_comb begin
		tok_head       = '0;
		tok_head.valid = launch;
		tok_head.take  = (action == ACT_TAKE);
	end

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		ukvt_cell #(
			.IDX       (i),
			.CW        (CW),
			.KEY_BITS  (KEY_BITS),
			.VALUE_BITS(VALUE_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.count      (count_q),
			.tok_in     ((i == 0) ? tok_head : tok[(i + TABLE_DEPTH - 1) % TABLE_DEPTH]),
			.tok_key_in ((i == 0) ? key : tok_key[(i + TABLE_DEPTH - 1) % TABLE_DEPTH]),
			.tok_val_in ((i == 0) ? value : tok_val[(i + TABLE_DEPTH - 1) % TABLE_DEPTH]),
			.tok_out    (tok[i]),
			.tok_key_out(tok_key[i]),
			.tok_val_out(tok_val[i]),
			.pull_in    ((i == TABLE_DEPTH - 1) ? 1'b0 : pull[(i + 1) % TABLE_DEPTH]),
			.nbr_key    (cell_key[(i + 1) % TABLE_DEPTH]),
			.nbr_val    (cell_val[(i + 1) % TABLE_DEPTH]),
			.pull_out   (pull[i]),
			.key_out    (cell_key[i]),
			.val_out    (cell_val[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			count_q     <= '0;
			done        <= 1'b0;
			status      <= ST_OK;
			out_key     <= '0;
			out_value   <= '0;
			entry_count <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (launch) begin
						state_q <= SCAN;
					end else if (accept) begin
						done      <= 1'b1;
						out_key   <= '0;
						out_value <= '0;
						unique case (action)
							ACT_PUT: begin
								status      <= ST_FULL;
								entry_count <= count_q;
							end
							ACT_TAKE: begin
								status      <= ST_EMPTY;
								entry_count <= count_q;
							end
							ACT_CLEAR: begin
								status      <= ST_OK;
								count_q     <= '0;
								entry_count <= '0;
							end
							default: begin
								status      <= ST_OK;
								entry_count <= count_q;
							end
						endcase
					end
				end
				SCAN: begin
					if (tail.valid) begin
						state_q   <= IDLE;
						done      <= 1'b1;
						out_key   <= '0;
						out_value <= '0;
						if (!tail.take) begin
							status <= ST_OK;
							if (tail.hit) begin
								entry_count <= count_q;
							end else begin
								count_q     <= count_q + 1'b1;
								entry_count <= count_q + 1'b1;
							end
						end else if (tail.hit) begin
							status      <= ST_OK;
							out_key     <= tok_key[TABLE_DEPTH-1];
							out_value   <= tok_val[TABLE_DEPTH-1];
							count_q     <= count_q - 1'b1;
							entry_count <= count_q - 1'b1;
						end else begin
							status      <= ST_NOKEY;
							entry_count <= count_q;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	// the first slot never sees a token that already found its key
	a_no_head_pull: assert property (@(posedge clk) disable iff (!arst_n) !pull[0])
		else $error("first cell asked to pull");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_tail_done: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |=> done && !busy)
		else $error("token left the row without a result");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		busy && $past(busy) && !$past(tail.valid) |-> $stable(count_q))
		else $error("entry count changed during a scan");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the unordered key/value table.
`timescale 1ns / 100ps

module testbench;
	import ukvt_pkg::*;

	localparam int          DEPTH       = 64;
	localparam logic [1:0]  ACT_UNUSED  = 2'd3;
	localparam int          STALL_LIMIT = 1000;
	localparam int          TAIL_CYCLES = DEPTH + 8;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] key;
		logic [15:0] value;
		logic [6:0]  count;
	} table_reply_t;

	// Tracks table contents and the replies still owed by the block.
	class table_tracker;
		logic [15:0]  keys [DEPTH];
		logic [15:0]  vals [DEPTH];
		int unsigned  fill;
		int unsigned  peak_fill;
		table_reply_t owed_replies[$];
		int unsigned  mismatches;
		int unsigned  failures;
		int unsigned  act_seen [4];
		int unsigned  status_seen [4];

		function new();
			fill = 0;
			peak_fill = 0;
			mismatches = 0;
			failures = 0;
			foreach (act_seen[i]) act_seen[i] = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function logic [15:0] held_key(int unsigned idx);
			return keys[idx];
		endfunction

		// Apply one accepted request to the shadow table, queue its reply.
		function void note_request(logic [1:0] act, logic [15:0] k, logic [15:0] v);
			table_reply_t r;
			int unsigned  pos;
			r = '0;
			r.status = ST_OK;
			pos = 0;
			while (pos < fill && keys[pos] != k) pos++;
			case (act)
				ACT_PUT: begin
					if (fill >= DEPTH) begin
						r.status = ST_FULL;
					end else if (pos < fill) begin
						vals[pos] = v;
					end else begin
						keys[fill] = k;
						vals[fill] = v;
						fill++;
					end
				end
				ACT_TAKE: begin
					if (fill == 0) begin
						r.status = ST_EMPTY;
					end else if (pos >= fill) begin
						r.status = ST_NOKEY;
					end else begin
						r.key = keys[pos];
						r.value = vals[pos];
						// order is not observable; fill the hole from the tail
						keys[pos] = keys[fill-1];
						vals[pos] = vals[fill-1];
						fill--;
					end
				end
				ACT_CLEAR: fill = 0;
				default: ;
			endcase
			r.count = fill[6:0];
			if (fill > peak_fill) peak_fill = fill;
			act_seen[act]++;
			status_seen[r.status]++;
			owed_replies.push_back(r);
		endfunction

		function void check_reply(table_reply_t got);
			table_reply_t exp_r;
			if (owed_replies.size() == 0) begin
				failures++;
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected reply status=%0d key=%h value=%h count=%0d",
						$realtime, got.status, got.key, got.value, got.count);
				return;
			end
			exp_r = owed_replies.pop_front();
			if (got !== exp_r) begin
				failures++;
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: exp/act status %0d/%0d key %h/%h value %h/%h count %0d/%0d",
						$realtime, exp_r.status, got.status, exp_r.key, got.key,
						exp_r.value, got.value, exp_r.count, got.count);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  action;
	logic [15:0] key;
	logic [15:0] value;
	logic        done;
	logic [1:0]  status;
	logic [15:0] out_key;
	logic [15:0] out_value;
	logic [6:0]  entry_count;

	table_tracker tracker = new();
	bit           idle_on;
	int           stall_cycles;

	unordered_key_value_table uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.key(key),
		.value(value),
		.done(done),
		.status(status),
		.out_key(out_key),
		.out_value(out_value),
		.entry_count(entry_count)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Reply monitor: sample before this edge's updates land.
	always @(posedge clk) begin
		if (arst_n && done)
			tracker.check_reply('{status, out_key, out_value, entry_count});
	end

	// Watchdog on cycles with neither a request nor a reply accepted.
	always @(posedge clk) begin
		if (done || (start && !busy)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("testbench failed");
				$finish;
			end
		end
	end

	// Issue one request; returns at the edge that accepts it.
	task automatic send_request(logic [1:0] act, logic [15:0] k, logic [15:0] v);
		if (idle_on && $urandom_range(99) < 36) begin
			start <= 1'b0;
			if ($urandom_range(9) == 0)
				repeat ($urandom_range(1, 80)) @(posedge clk);
			else
				repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start  <= 1'b1;
		action <= act;
		key    <= k;
		value  <= v;
		do @(posedge clk); while (busy);
		tracker.note_request(act, k, v);
	endtask

	task automatic run_directed();
		send_request(ACT_TAKE, 16'h1234, 16'hFFFF);     // take on empty
		send_request(ACT_PUT, 16'h0000, 16'h0000);
		send_request(ACT_PUT, 16'hFFFF, 16'hFFFF);
		send_request(ACT_PUT, 16'h0000, 16'hA5A5);      // update held key
		send_request(ACT_TAKE, 16'h5555, 16'h0000);     // absent key
		send_request(ACT_UNUSED, 16'hFFFF, 16'hFFFF);
		send_request(ACT_TAKE, 16'h0000, 16'h0000);     // not last: tail moves in
		send_request(ACT_TAKE, 16'hFFFF, 16'h0000);
		send_request(ACT_TAKE, 16'hFFFF, 16'h0000);     // now empty again
		send_request(ACT_PUT, 16'h0001, 16'h0002);
		send_request(ACT_PUT, 16'h0002, 16'h0003);
		send_request(ACT_PUT, 16'h0003, 16'h0004);
		send_request(ACT_TAKE, 16'h0001, 16'h0000);
		send_request(ACT_CLEAR, 16'hFFFF, 16'hFFFF);    // stale entries remain
		send_request(ACT_TAKE, 16'h0003, 16'h0000);
		send_request(ACT_PUT, 16'h8000, 16'h0001);
		send_request(ACT_PUT, 16'h7FFF, 16'h8000);
		send_request(ACT_TAKE, 16'h7FFF, 16'h0000);
		send_request(ACT_CLEAR, 16'h0000, 16'h0000);
		send_request(ACT_UNUSED, 16'h0000, 16'h0000);
		send_request(ACT_CLEAR, 16'h0000, 16'h0000);
	endtask

	task automatic run_random(int n_items);
		typedef enum int {MODE_MIX, MODE_FILL, MODE_DRAIN} walk_mode_t;
		walk_mode_t  mode;
		int          full_tries;
		int          empty_tries;
		int          mix_left;
		int          r;
		logic [1:0]  act;
		logic [15:0] k;
		mode = MODE_FILL;
		full_tries = 0;
		empty_tries = 0;
		mix_left = 0;
		for (int i = 0; i < n_items; i++) begin
			idle_on = !(i >= 150 && i < 250);
			if (mode == MODE_FILL && tracker.fill == DEPTH && full_tries >= 4) begin
				mode = MODE_DRAIN;
				empty_tries = 0;
			end else if (mode == MODE_DRAIN && tracker.fill == 0 && empty_tries >= 3) begin
				mode = MODE_MIX;
				mix_left = 40;
			end else if (mode == MODE_MIX && mix_left == 0) begin
				mode = MODE_FILL;
				full_tries = 0;
			end
			if (tracker.fill == DEPTH) full_tries++;
			if (tracker.fill == 0) empty_tries++;
			r = $urandom_range(99);
			case (mode)
				MODE_FILL:  act = (r < 85) ? ACT_PUT : ACT_TAKE;
				MODE_DRAIN: act = (r < 85) ? ACT_TAKE : ACT_PUT;
				default: begin
					mix_left--;
					if (r < 46)      act = ACT_PUT;
					else if (r < 92) act = ACT_TAKE;
					else if (r < 96) act = ACT_UNUSED;
					else             act = ACT_CLEAR;
				end
			endcase
			k = 16'($urandom());
			// reuse a held key often so updates and hits happen
			if (tracker.fill != 0) begin
				if ((act == ACT_PUT && $urandom_range(99) < 25) ||
				    (act == ACT_TAKE && $urandom_range(99) < 80))
					k = tracker.held_key($urandom_range(tracker.fill - 1));
			end
			send_request(act, k, 16'($urandom()));
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start  <= 1'b0;
		action <= ACT_PUT;
		key    <= '0;
		value  <= '0;
		stall_cycles = 0;
		idle_on = 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random(480);
		start <= 1'b0;
		while (tracker.owed_replies.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		tracker.failures += tracker.owed_replies.size();
		$display("requests: %0d put, %0d take, %0d clear, %0d unused code; peak fill %0d",
			tracker.act_seen[ACT_PUT], tracker.act_seen[ACT_TAKE],
			tracker.act_seen[ACT_CLEAR], tracker.act_seen[ACT_UNUSED], tracker.peak_fill);
		$display("replies: %0d ok, %0d no key, %0d empty, %0d full; %0d mismatches",
			tracker.status_seen[ST_OK], tracker.status_seen[ST_NOKEY],
			tracker.status_seen[ST_EMPTY], tracker.status_seen[ST_FULL],
			tracker.mismatches);
		if (tracker.failures == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

@@ unordered_key_value_table.f @@
hw/rtl/ukvt_pkg.sv
hw/rtl/ukvt_cell.sv
hw/rtl/unordered_key_value_table.sv
verif/testbench.sv
